// ===== rtl/two_stack_queue_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TWO_STACK_QUEUE_DEFINES_SVH
`define TWO_STACK_QUEUE_DEFINES_SVH

// Check an implication in the same cycle.
`define TSQ_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check an implication in the next cycle.
`define TSQ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tsq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_W = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOVE = 4'b0010,
    S_RD   = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tsq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface tsq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Result channel
interface tsq_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] front_value;
  logic [1:0]  status;
  logic        queue_empty;

  modport source (output valid, output front_value, output status, output queue_empty,
                  input ready);
  modport sink   (input valid, input front_value, input status, input queue_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tsq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_stack_queue.sv =====
// Queue of 32-bit words built from an input stack and an output stack in two RAMs.
// Enqueue and empty-queue results appear in the cycle after accept, one beat per cycle
// while the result is taken. Dequeue/peek with a filled output stack goes through
// S_RD (registered output-stack RAM read) and S_RESP (result load, held for a free
// result register). A refill from the input stack runs S_MOVE, one RAM move a cycle.
// Synchronous reset clears both stack counts; RAM contents stay undefined, no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module two_stack_queue #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tsq_in_if.sink     in_ch,
  tsq_out_if.source  out_ch
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  tsq_pkg::state_t state, state_next;

  logic [CW-1:0] in_count, in_count_next;
  logic [CW-1:0] out_count, out_count_next;
  logic [CW-1:0] in_count_m1, out_count_m1;
  logic          mv_pend, mv_pend_next;
  logic          op_deq, op_deq_next;

  logic in_we, in_re, out_we, out_re;
  logic [tsq_pkg::DATA_W-1:0] in_rdata, out_rdata;

  logic                       out_valid;
  logic [tsq_pkg::DATA_W-1:0] out_front;
  logic [1:0]                 out_status;
  logic                       out_empty;
  logic                       out_free;

  logic                       res_load;
  logic [tsq_pkg::DATA_W-1:0] res_front;
  logic [1:0]                 res_status;
  logic                       res_empty;

  assign in_count_m1  = in_count - CW'(1);
  assign out_count_m1 = out_count - CW'(1);
  assign out_free     = !out_valid || out_ch.ready;
  assign in_ch.ready  = (state == tsq_pkg::S_IDLE) && out_free;

  // Input stack: push at the count, pop from the top during a refill
  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_count[AW-1:0]),
    .wdata (in_ch.value),
    .re    (in_re),
    .raddr (in_count_m1[AW-1:0]),
    .rdata (in_rdata)
  );

  // Output stack: filled during a refill, read at the top
  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_count[AW-1:0]),
    .wdata (in_rdata),
    .re    (out_re),
    .raddr (out_count_m1[AW-1:0]),
    .rdata (out_rdata)
  );

  // Sequence commands, refills and top reads
  always_comb begin
    state_next     = state;
    in_count_next  = in_count;
    out_count_next = out_count;
    mv_pend_next   = 1'b0;
    op_deq_next    = op_deq;
    in_we          = 1'b0;
    in_re          = 1'b0;
    out_we         = 1'b0;
    out_re         = 1'b0;
    res_load       = 1'b0;
    res_front      = '0;
    res_status     = tsq_pkg::ST_OK;
    unique case (state)
      tsq_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          unique case (in_ch.opcode)
            tsq_pkg::OP_ENQ: begin
              res_load = 1'b1;
              if (in_count == CW'(STACK_DEPTH)) begin
                res_status = tsq_pkg::ST_FULL;
              end else begin
                in_we         = 1'b1;
                in_count_next = in_count + CW'(1);
              end
            end
            tsq_pkg::OP_DEQ, tsq_pkg::OP_PEEK: begin
              op_deq_next = (in_ch.opcode == tsq_pkg::OP_DEQ);
              if (out_count != '0) begin
                state_next = tsq_pkg::S_RD;
              end else if (in_count != '0) begin
                state_next = tsq_pkg::S_MOVE;
              end else begin
                res_load   = 1'b1;
                res_status = tsq_pkg::ST_EMPTY;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      tsq_pkg::S_MOVE: begin
        // issue a pop read, write the word read last cycle
        if (in_count != '0) begin
          in_re         = 1'b1;
          in_count_next = in_count_m1;
          mv_pend_next  = 1'b1;
        end
        if (mv_pend) begin
          out_we         = 1'b1;
          out_count_next = out_count + CW'(1);
        end
        if (in_count == '0 && !mv_pend) begin
          state_next = tsq_pkg::S_RD;
        end
      end
      tsq_pkg::S_RD: begin
        out_re     = 1'b1;
        state_next = tsq_pkg::S_RESP;
      end
      tsq_pkg::S_RESP: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_front = out_rdata;
          if (op_deq) begin
            out_count_next = out_count_m1;
          end
          state_next = tsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsq_pkg::S_IDLE;
      end
    endcase
    res_empty = (in_count_next == '0) && (out_count_next == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsq_pkg::S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      mv_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      in_count  <= in_count_next;
      out_count <= out_count_next;
      mv_pend   <= mv_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op_deq <= op_deq_next;
  end

  // Result register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_front  <= res_front;
      out_status <= res_status;
      out_empty  <= res_empty;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.front_value = out_front;
  assign out_ch.status      = out_status;
  assign out_ch.queue_empty = out_empty;

endmodule

`default_nettype wire

// ===== rtl/tsq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "two_stack_queue_defines.svh"

module tsq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] front_value,
  input wire logic [1:0]  status,
  input wire logic        queue_empty
);

  // Hold a stalled result beat
  `TSQ_ASSERT_NEXT(a_valid_hold, clk, rst, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `TSQ_ASSERT_NEXT(a_front_hold, clk, rst, out_valid && !out_ready, $stable(front_value), "stalled front value changed")

  // A rejected enqueue delivers no word and leaves a nonempty queue
  `TSQ_ASSERT_NOW(a_full_result, clk, rst, out_valid && status == tsq_pkg::ST_FULL, front_value == '0 && !queue_empty, "full status with word or empty queue")

  // An empty status delivers no word and reports the queue empty
  `TSQ_ASSERT_NOW(a_empty_result, clk, rst, out_valid && status == tsq_pkg::ST_EMPTY, front_value == '0 && queue_empty, "empty status inconsistent")

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .front_value (out_ch.front_value),
  .status      (out_ch.status),
  .queue_empty (out_ch.queue_empty)
);

`default_nettype wire
